// ----- hw/rtl/sraa_pkg.sv -----
// Package for the sample ring average alarm: sizes, codes and item types.
`timescale 1ns / 1ps

package sraa_pkg;

    localparam int LOG_DEPTH  = 32;
    localparam int IDX_W      = $clog2(LOG_DEPTH);
    localparam int CNT_W      = $clog2(LOG_DEPTH + 1);
    localparam int SMP_W      = 16;
    localparam int STAMP_W    = 32;
    localparam int SUM_W      = SMP_W + CNT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LOG_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LOG_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT     = 2'd2;

    // compare modes
    localparam logic [1:0] CMP_ABOVE = 2'd0;
    localparam logic [1:0] CMP_BELOW = 2'd1;
    localparam logic [1:0] CMP_EQUAL = 2'd2;

    // commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ALARM_NORMAL  = 2'd0,
        ALARM_RAISED  = 2'd1,
        ALARM_UNKNOWN = 2'd2
    } t_alarm;

    typedef struct packed {
        logic                    cmd;
        logic signed [SMP_W-1:0] sample_first;
        logic signed [SMP_W-1:0] sample_second;
        logic signed [SMP_W-1:0] sample_third;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_first;
        logic signed [SMP_W-1:0] out_second;
        logic signed [SMP_W-1:0] out_third;
        logic [STAMP_W-1:0]      out_stamp;
        logic [1:0]              alarm_status;
        logic [CNT_W-1:0]        entry_count;
        logic                    underflow;
    } t_out_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] first;
        logic signed [SMP_W-1:0] second;
        logic signed [SMP_W-1:0] third;
        logic [STAMP_W-1:0]      stamp;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_log_wr;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_LAST : IDX_W'(idx - 1'b1);
    endfunction

endpackage

// ----- hw/rtl/sraa_log.sv -----
// Entry store of the ring log: one write port, two registered read ports.
`timescale 1ns / 1ps

module sraa_log (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sraa_pkg::t_log_wr     i_wr,
    input  logic [sraa_pkg::IDX_W-1:0] i_rd_a_addr,
    input  logic [sraa_pkg::IDX_W-1:0] i_rd_b_addr,
    output sraa_pkg::t_entry      o_rd_a,
    output logic signed [sraa_pkg::SMP_W-1:0] o_rd_b_first
);
    import sraa_pkg::*;

    t_entry                  r_mem [LOG_DEPTH];
    logic [LOG_DEPTH-1:0]    r_valid;
    t_entry                  r_rd_a;
    logic                    r_rd_a_valid;
    logic signed [SMP_W-1:0] r_rd_b_first;
    logic                    r_byp;
    t_entry                  r_byp_entry;
    t_entry                  w_rd_a;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_a       <= r_mem[i_rd_a_addr];
        r_rd_b_first <= r_mem[i_rd_b_addr].first;
        r_byp_entry  <= i_wr.entry;
    end

    // stamps read as zero until their slot is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_rd_a_valid <= 1'b0;
            r_byp        <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_a_valid <= r_valid[i_rd_a_addr];
            r_byp        <= i_wr.en && (i_wr.addr == i_rd_a_addr);
        end
    end

    always_comb begin
        w_rd_a = r_rd_a;
        if (!r_rd_a_valid) begin
            w_rd_a.stamp = '0;
        end
        if (r_byp) begin
            w_rd_a = r_byp_entry;
        end
    end

    assign o_rd_a       = w_rd_a;
    assign o_rd_b_first = r_rd_b_first;

endmodule

// ----- hw/rtl/sample_ring_average_alarm.sv -----
// Top level of the sample ring average alarm: control, running sum and result register.
`timescale 1ns / 1ps

// Ring log of three-value samples with an average alarm on the first value.
// Input channel: i_in_valid / o_in_stall carry an item with cmd (push or pop)
// and three samples. Output channel: o_out_valid / i_out_stall carry one
// result item per input item, in order.
// The result is written to the output register at the edge that accepts the
// item. Throughput: one item per cycle while the receiver takes results.
// The entry store is read ahead at the next top slot and its neighbour, so
// every push or pop is one read-modify-write of the state.
// The alarm compares the running sum with setpoint times count exactly.
// When the receiver stalls, the result is held and the input stalls in the
// same cycle; nothing is dropped. Configuration writes on i_cfg_we take
// effect at the next edge; the user must make them while the block is idle; it is not enforced.
// Reset (synchronous, active low) empties the log, clears stamps, sets the
// alarm to unknown and the registers to zero; no clearing pass is needed.
module sample_ring_average_alarm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sraa_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sraa_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [sraa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sraa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sraa_pkg::*;

    logic                    r_alarm_enable;
    logic [1:0]              r_compare_mode;
    logic signed [SMP_W-1:0] r_setpoint;

    logic [IDX_W-1:0]        r_top,   n_top;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum,   n_sum;
    t_alarm                  r_alarm, n_alarm;

    logic                    r_out_valid;
    t_out_item               r_out_item, n_out_item;

    logic                    w_accept;
    logic                    w_full;
    logic [IDX_W-1:0]        w_push_slot;
    logic [IDX_W-1:0]        w_rd_addr;
    t_log_wr                 w_wr;
    t_entry                  w_top_entry;
    logic signed [SMP_W-1:0] w_old_first;
    logic signed [SUM_W:0]   w_target;
    logic signed [SUM_W:0]   w_sum_ext;
    logic                    w_hit;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count >= CNT_FULL);
    assign w_push_slot = idx_inc(r_top);

    // read ahead at the top slot that the next item will see
    assign w_rd_addr = !i_rst_n ? '0 : (w_accept ? n_top : r_top);

    sraa_log u_log (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_wr),
        .i_rd_a_addr  (w_rd_addr),
        .i_rd_b_addr  (idx_inc(w_rd_addr)),
        .o_rd_a       (w_top_entry),
        .o_rd_b_first (w_old_first)
    );

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        n_sum   = r_sum;
        n_alarm = r_alarm;

        w_wr             = '0;
        w_wr.addr        = w_push_slot;
        w_wr.entry.first  = i_in_item.sample_first;
        w_wr.entry.second = i_in_item.sample_second;
        w_wr.entry.third  = i_in_item.sample_third;
        w_wr.entry.stamp  = STAMP_W'(w_top_entry.stamp + 1'b1);

        n_out_item              = '0;
        n_out_item.alarm_status = r_alarm;
        n_out_item.entry_count  = r_count;

        w_target  = '0;
        w_sum_ext = '0;
        w_hit     = 1'b0;

        if (i_in_item.cmd == CMD_PUSH) begin
            w_wr.en = w_accept;
            n_top   = w_push_slot;
            if (w_full) begin
                n_sum = SUM_W'(r_sum - SUM_W'(w_old_first) + SUM_W'(i_in_item.sample_first));
            end else begin
                n_count = CNT_W'(r_count + 1'b1);
                n_sum   = SUM_W'(r_sum + SUM_W'(i_in_item.sample_first));
            end

            // average against setpoint without division: sum vs setpoint * count
            w_target  = (SUM_W+1)'(r_setpoint * $signed({1'b0, n_count}));
            w_sum_ext = (SUM_W+1)'(n_sum);
            case (r_compare_mode)
                CMP_ABOVE: w_hit = (w_sum_ext > w_target);
                CMP_BELOW: w_hit = (w_sum_ext < w_target);
                CMP_EQUAL: w_hit = (w_sum_ext == w_target);
                default:   w_hit = 1'b0;
            endcase
            if (r_alarm_enable) begin
                if (n_count < CNT_W'(2)) begin
                    n_alarm = ALARM_UNKNOWN;
                end else begin
                    n_alarm = w_hit ? ALARM_RAISED : ALARM_NORMAL;
                end
            end

            n_out_item.out_stamp = w_wr.entry.stamp;
        end else if (r_count == '0) begin
            n_out_item.underflow = 1'b1;
        end else begin
            n_top   = idx_dec(r_top);
            n_count = CNT_W'(r_count - 1'b1);
            n_sum   = SUM_W'(r_sum - SUM_W'(w_top_entry.first));

            n_out_item.out_first  = w_top_entry.first;
            n_out_item.out_second = w_top_entry.second;
            n_out_item.out_third  = w_top_entry.third;
            n_out_item.out_stamp  = w_top_entry.stamp;
        end

        n_out_item.alarm_status = n_alarm;
        n_out_item.entry_count  = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_enable <= 1'b0;
            r_compare_mode <= CMP_ABOVE;
            r_setpoint     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALARM_ENABLE: r_alarm_enable <= i_cfg_data[0];
                REG_COMPARE_MODE: r_compare_mode <= i_cfg_data[1:0];
                REG_SETPOINT:     r_setpoint     <= $signed(i_cfg_data);
                default:          r_alarm_enable <= r_alarm_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_alarm     <= ALARM_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_top       <= n_top;
                r_count     <= n_count;
                r_sum       <= n_sum;
                r_alarm     <= n_alarm;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- sim/tb_sample_ring_average_alarm.sv -----
// Self-checking testbench for the sample ring average alarm: directed table, then random phases.
`timescale 1ns / 1ps

module tb_sample_ring_average_alarm;
    import sraa_pkg::*;

    localparam int          RANDOM_ITEMS   = 1900;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam logic [1:0]  CMP_UNUSED     = 2'd3;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TYPED,
        ROW_REGS
    } t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_in_item                item;
        t_out_item               want;
        logic                    en;
        logic [1:0]              mode;
        logic signed [SMP_W-1:0] sp;
    } t_row;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    t_in_item                 in_item   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_item;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    // shadow of the log, the running sum and the registers
    logic signed [SMP_W-1:0]  first_mem  [LOG_DEPTH];
    logic signed [SMP_W-1:0]  second_mem [LOG_DEPTH];
    logic signed [SMP_W-1:0]  third_mem  [LOG_DEPTH];
    logic [STAMP_W-1:0]       stamp_mem  [LOG_DEPTH];
    logic [IDX_W-1:0]         top_idx    = '0;
    logic [CNT_W-1:0]         held       = '0;
    longint                   run_sum    = 0;
    t_alarm                   level      = ALARM_UNKNOWN;
    logic                     alarm_on   = 1'b0;
    logic [1:0]               cmp_mode   = CMP_ABOVE;
    logic signed [SMP_W-1:0]  set_point  = '0;

    t_out_item                pending_results [$];
    t_row                     script [$];
    int                       mismatch_count = 0;
    int                       quiet_cycles   = 0;
    int                       burst_left     = 0;
    logic                     gaps_on        = 1'b1;
    int                       stall_span     = 0;
    int                       stall_style    = 0;

    sample_ring_average_alarm dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_in_item mk_in(input logic cmd, input logic [15:0] a,
                                       input logic [15:0] b, input logic [15:0] c);
        t_in_item r;
        r.cmd           = cmd;
        r.sample_first  = a;
        r.sample_second = b;
        r.sample_third  = c;
        return r;
    endfunction

    function automatic t_out_item mk_out(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [31:0] stamp,
                                         input t_alarm alarm, input int count,
                                         input logic under);
        t_out_item r;
        r.out_first    = a;
        r.out_second   = b;
        r.out_third    = c;
        r.out_stamp    = stamp;
        r.alarm_status = alarm;
        r.entry_count  = CNT_W'(count);
        r.underflow    = under;
        return r;
    endfunction

    // one push or pop applied to the shadow log
    function automatic t_out_item ring_log_step(input t_in_item it);
        t_out_item        r;
        logic [IDX_W-1:0] slot;
        longint           target;
        logic             hit;
        r = '0;
        if (it.cmd == CMD_PUSH) begin
            slot = (top_idx == IDX_LAST) ? '0 : top_idx + 1'b1;
            // full log: the overwritten slot is the oldest in the window
            if (held == CNT_FULL) begin
                run_sum = run_sum - first_mem[slot];
            end else begin
                held = held + 1'b1;
            end
            r.out_stamp       = stamp_mem[top_idx] + 1'b1;
            top_idx           = slot;
            first_mem[slot]   = it.sample_first;
            second_mem[slot]  = it.sample_second;
            third_mem[slot]   = it.sample_third;
            stamp_mem[slot]   = r.out_stamp;
            run_sum           = run_sum + it.sample_first;
            if (alarm_on) begin
                if (held < 2) begin
                    level = ALARM_UNKNOWN;
                end else begin
                    target = longint'(set_point) * longint'(held);
                    case (cmp_mode)
                        CMP_ABOVE: hit = run_sum > target;
                        CMP_BELOW: hit = run_sum < target;
                        CMP_EQUAL: hit = run_sum == target;
                        default:   hit = 1'b0;
                    endcase
                    level = hit ? ALARM_RAISED : ALARM_NORMAL;
                end
            end
        end else if (held == 0) begin
            r.underflow = 1'b1;
        end else begin
            r.out_first  = first_mem[top_idx];
            r.out_second = second_mem[top_idx];
            r.out_third  = third_mem[top_idx];
            r.out_stamp  = stamp_mem[top_idx];
            run_sum      = run_sum - first_mem[top_idx];
            held         = held - 1'b1;
            top_idx      = (top_idx == '0) ? IDX_LAST : top_idx - 1'b1;
        end
        r.alarm_status = level;
        r.entry_count  = held;
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            return SMP_W'($urandom);
        end else if (sel < 55) begin
            case ($urandom_range(3))
                0:       return 16'sh8000;
                1:       return 16'sh7fff;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        // near the setpoint so that the window average lands on all sides of it
        v = int'(set_point);
        if ($urandom_range(1) == 0) begin
            v = v + int'($urandom_range(6)) - 3;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SMP_W'(v);
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %s: expected %h, got %h", what, want, got);
        end
    endtask

    // offer one item, wait for it to be taken, then maybe open a gap
    task automatic offer_item(input t_in_item it, input t_out_item typed_want,
                              input logic use_typed);
        t_out_item predicted;
        int        gap;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!(in_valid && !in_stall));
        predicted = ring_log_step(it);
        pending_results.push_back(use_typed ? typed_want : predicted);
        gap = 0;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // registers only change once the block has drained
    task automatic write_regs(input logic en, input logic [1:0] mode,
                              input logic signed [SMP_W-1:0] sp);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALARM_ENABLE;
        cfg_data  <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_index <= REG_COMPARE_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= REG_SETPOINT;
        cfg_data  <= sp;
        @(posedge clk);
        cfg_we    <= 1'b0;
        alarm_on  = en;
        cmp_mode  = mode;
        set_point = sp;
    endtask

    // receiver stall pattern, switching style every so often
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_style <= $urandom_range(3);
            stall_span  <= $urandom_range(20, 200);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(3) == 0);
            2:       out_stall <= ($urandom_range(3) != 0);
            default: out_stall <= (stall_span[3:0] < 6);
        endcase
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report("result with none pending", '0, out_item.out_stamp);
            end else begin
                want = pending_results.pop_front();
                if (out_item.out_first !== want.out_first)
                    report("out_first", want.out_first, out_item.out_first);
                if (out_item.out_second !== want.out_second)
                    report("out_second", want.out_second, out_item.out_second);
                if (out_item.out_third !== want.out_third)
                    report("out_third", want.out_third, out_item.out_third);
                if (out_item.out_stamp !== want.out_stamp)
                    report("out_stamp", want.out_stamp, out_item.out_stamp);
                if (out_item.alarm_status !== want.alarm_status)
                    report("alarm_status", want.alarm_status, out_item.alarm_status);
                if (out_item.entry_count !== want.entry_count)
                    report("entry_count", want.entry_count, out_item.entry_count);
                if (out_item.underflow !== want.underflow)
                    report("underflow", want.underflow, out_item.underflow);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        int                      random_sent;
        int                      span;
        int                      push_pct;
        logic signed [SMP_W-1:0] sp;
        t_in_item                it;

        for (int k = 0; k < LOG_DEPTH; k++) begin
            first_mem[k]  = '0;
            second_mem[k] = '0;
            third_mem[k]  = '0;
            stamp_mem[k]  = '0;
        end

        // alarm off after reset: underflow, extremes, stamps from zero
        script.push_back('{ROW_TYPED, mk_in(CMD_POP, 16'h0000, 16'h0000, 16'h0000),
                           mk_out(0, 0, 0, 0, ALARM_UNKNOWN, 0, 1'b1), 0, CMP_ABOVE, 0});
        script.push_back('{ROW_TYPED, mk_in(CMD_PUSH, 16'h7fff, 16'h8000, 16'h0001),
                           mk_out(0, 0, 0, 1, ALARM_UNKNOWN, 1, 1'b0), 0, CMP_ABOVE, 0});
        script.push_back('{ROW_TYPED, mk_in(CMD_POP, 16'hffff, 16'hffff, 16'hffff),
                           mk_out(16'h7fff, 16'h8000, 16'h0001, 1, ALARM_UNKNOWN, 0, 1'b0),
                           0, CMP_ABOVE, 0});
        script.push_back('{ROW_TYPED, mk_in(CMD_POP, 16'h8000, 16'h7fff, 16'h5555),
                           mk_out(0, 0, 0, 0, ALARM_UNKNOWN, 0, 1'b1), 0, CMP_ABOVE, 0});
        // average above the setpoint
        script.push_back('{ROW_REGS, '0, '0, 1'b1, CMP_ABOVE, 16'sh0010});
        script.push_back('{ROW_TYPED, mk_in(CMD_PUSH, 16'h8000, 16'h7fff, 16'hffff),
                           mk_out(0, 0, 0, 1, ALARM_UNKNOWN, 1, 1'b0), 0, CMP_ABOVE, 0});
        script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h7fff, 16'h0000, 16'h0000),
                           '0, 0, CMP_ABOVE, 0});
        script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h7fff, 16'haaaa, 16'h5555),
                           '0, 0, CMP_ABOVE, 0});
        // a pop keeps the alarm as it was
        script.push_back('{ROW_ITEM, mk_in(CMD_POP, 16'h0000, 16'h0000, 16'h0000),
                           '0, 0, CMP_ABOVE, 0});
        script.push_back('{ROW_REGS, '0, '0, 1'b1, CMP_BELOW, 16'sh8000});
        script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h0010, 16'h1234, 16'hedcb),
                           '0, 0, CMP_ABOVE, 0});
        // drain, then two pushes exactly on the setpoint
        script.push_back('{ROW_REGS, '0, '0, 1'b1, CMP_EQUAL, 16'sh0010});
        repeat (4) begin
            script.push_back('{ROW_ITEM, mk_in(CMD_POP, 16'h0000, 16'h0000, 16'h0000),
                               '0, 0, CMP_ABOVE, 0});
        end
        repeat (2) begin
            script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h0010, 16'h0f0f, 16'hf0f0),
                               '0, 0, CMP_ABOVE, 0});
        end
        script.push_back('{ROW_REGS, '0, '0, 1'b1, CMP_UNUSED, 16'sh7fff});
        script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h0010, 16'h0000, 16'h0000),
                           '0, 0, CMP_ABOVE, 0});
        // alarm off: level holds
        script.push_back('{ROW_REGS, '0, '0, 1'b0, CMP_ABOVE, 16'sh8000});
        script.push_back('{ROW_ITEM, mk_in(CMD_PUSH, 16'h7fff, 16'h7fff, 16'h7fff),
                           '0, 0, CMP_ABOVE, 0});
        script.push_back('{ROW_ITEM, mk_in(CMD_POP, 16'h0000, 16'h0000, 16'h0000),
                           '0, 0, CMP_ABOVE, 0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REGS) begin
                write_regs(script[i].en, script[i].mode, script[i].sp);
            end else begin
                offer_item(script[i].item, script[i].want, script[i].kind == ROW_TYPED);
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(4))
                0:       sp = 16'sh8000;
                1:       sp = 16'sh7fff;
                2:       sp = SMP_W'($urandom);
                default: sp = SMP_W'(int'($urandom_range(1023)) - 512);
            endcase
            write_regs($urandom_range(9) != 0, 2'($urandom_range(2)), sp);
            gaps_on = ($urandom_range(3) != 0);
            // fill, mix or drain the log
            case ($urandom_range(3))
                0:       push_pct = 90;
                1:       push_pct = 75;
                2:       push_pct = 50;
                default: push_pct = 25;
            endcase
            span = $urandom_range(60, 250);
            repeat (span) begin
                it.cmd           = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                it.sample_first  = pick_sample();
                it.sample_second = SMP_W'($urandom);
                it.sample_third  = SMP_W'($urandom);
                offer_item(it, '0, 1'b0);
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
